[design/wre_pkg.sv]
// wre_pkg: shared types and constants of the wheel rpm estimator.
// No dependencies; imported by the interfaces and all design modules.

package wre_pkg;

    localparam int N_WHEELS     = 4;
    localparam int W_WHEEL      = $clog2(N_WHEELS);
    localparam int W_TIME       = 32;
    localparam int W_CNT        = 16;
    localparam int W_RPM        = 22;
    localparam int W_PPR        = 16;
    localparam int W_GAIN       = 9;
    localparam int W_LIM        = 10;
    localparam int W_INV        = N_WHEELS;
    localparam int W_CFG_IDX    = 2;
    localparam int W_CFG_DATA   = 16;
    // |delta| * 60000 < 2^31, pulses_per_rev * elapsed < 2^26
    localparam int W_NUM        = 31;
    localparam int W_DEN        = W_PPR + W_LIM;
    localparam int FRAC_BITS_DEF = 8;

    localparam logic [W_RPM-2:0] RPM_LIMIT  = 21'd1787291;
    localparam logic [15:0]      MS_PER_MIN = 16'd60000;
    localparam logic [W_GAIN-1:0] GAIN_ONE  = 9'd256;

    localparam logic [W_PPR-1:0]  PPR_RST  = 16'd1100;
    localparam logic [W_GAIN-1:0] GAIN_RST = 9'd51;
    localparam logic [W_LIM-1:0]  LIM_RST  = 10'd100;
    localparam logic [W_INV-1:0]  INV_RST  = 4'd12;

    typedef enum logic [W_CFG_IDX-1:0] {
        CFG_PPR  = 2'd0,
        CFG_GAIN = 2'd1,
        CFG_LIM  = 2'd2,
        CFG_INV  = 2'd3
    } t_cfg_idx;

    // effective configuration, corner values already folded
    typedef struct packed {
        logic [W_PPR-1:0]  ppr;
        logic [W_GAIN-1:0] gain;
        logic [W_LIM-1:0]  lim;
        logic [W_INV-1:0]  inv;
    } t_cfg;

endpackage

[design/wre_if.sv]
// wre_if: valid/ready channel interfaces of the wheel rpm estimator.
// Depends on wre_pkg.

interface wre_in_if;
    import wre_pkg::*;
    logic              valid;
    logic              ready;
    logic [W_TIME-1:0] time_ms;
    logic [W_CNT-1:0]  count_wheel1;
    logic [W_CNT-1:0]  count_wheel2;
    logic [W_CNT-1:0]  count_wheel3;
    logic [W_CNT-1:0]  count_wheel4;

    modport source (output valid, time_ms, count_wheel1, count_wheel2,
                    count_wheel3, count_wheel4, input ready);
    modport sink   (input valid, time_ms, count_wheel1, count_wheel2,
                    count_wheel3, count_wheel4, output ready);
endinterface

interface wre_out_if;
    import wre_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [W_RPM-1:0] rpm_wheel1;
    logic signed [W_RPM-1:0] rpm_wheel2;
    logic signed [W_RPM-1:0] rpm_wheel3;
    logic signed [W_RPM-1:0] rpm_wheel4;
    logic signed [W_RPM-1:0] mean_rpm;

    modport source (output valid, rpm_wheel1, rpm_wheel2, rpm_wheel3,
                    rpm_wheel4, mean_rpm, input ready);
    modport sink   (input valid, rpm_wheel1, rpm_wheel2, rpm_wheel3,
                    rpm_wheel4, mean_rpm, output ready);
endinterface

interface wre_cfg_if;
    import wre_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [W_CFG_IDX-1:0]  index;
    logic [W_CFG_DATA-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/wre_cfg.sv]
// wre_cfg: configuration registers; presents effective values as a struct.
// Depends on wre_pkg and wre_if.

module wre_cfg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    wre_cfg_if.sink          i_cfg,
    output wre_pkg::t_cfg    o_cfg
);
    import wre_pkg::*;

    logic [W_PPR-1:0]  r_ppr;
    logic [W_GAIN-1:0] r_gain;
    logic [W_LIM-1:0]  r_lim;
    logic [W_INV-1:0]  r_inv;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr  <= PPR_RST;
            r_gain <= GAIN_RST;
            r_lim  <= LIM_RST;
            r_inv  <= INV_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_PPR:  r_ppr  <= i_cfg.data[W_PPR-1:0];
                CFG_GAIN: r_gain <= i_cfg.data[W_GAIN-1:0];
                CFG_LIM:  r_lim  <= i_cfg.data[W_LIM-1:0];
                CFG_INV:  r_inv  <= i_cfg.data[W_INV-1:0];
            endcase
        end
    end

    // zero ppr or interval behaves as one, gain saturates at unity
    always_comb begin
        o_cfg.ppr  = (r_ppr == '0) ? W_PPR'(1) : r_ppr;
        o_cfg.lim  = (r_lim == '0) ? W_LIM'(1) : r_lim;
        o_cfg.gain = (r_gain > GAIN_ONE) ? GAIN_ONE : r_gain;
        o_cfg.inv  = r_inv;
    end

endmodule

[design/wre_div.sv]
// wre_div: unsigned restoring divider, one quotient bit per cycle.
// Depends on wre_pkg for default widths.

module wre_div #(
    parameter int W_N = wre_pkg::W_NUM,
    parameter int W_D = wre_pkg::W_DEN
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W_N-1:0] i_num,
    input  logic [W_D-1:0] i_den,
    output logic           o_busy,
    output logic [W_N-1:0] o_quot
);
    import wre_pkg::*;

    localparam int W_C = $clog2(W_N + 1);

    logic [W_C-1:0] r_cnt;
    logic [W_D-1:0] r_rem;
    logic [W_N-1:0] r_q;
    logic [W_D-1:0] r_den;
    logic [W_D:0]   trial;
    logic           fits;

    assign trial  = {r_rem, r_q[W_N-1]};
    assign fits   = trial >= {1'b0, r_den};
    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= W_C'(W_N);
        end else if (o_busy) begin
            r_cnt <= r_cnt - W_C'(1);
        end
    end

    // numerator shifts out at the top while quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (o_busy) begin
            r_rem <= fits ? W_D'(trial - {1'b0, r_den}) : trial[W_D-1:0];
            r_q   <= {r_q[W_N-2:0], fits};
        end
    end

endmodule

[design/wre_wheel_ram.sv]
// wre_wheel_ram: per-wheel state memory {previous count, filter state},
// registered read; entries never written since reset read as zero.
// Depends on wre_pkg.

module wre_wheel_ram #(
    parameter int W_DATA = wre_pkg::W_CNT + wre_pkg::W_RPM + wre_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [wre_pkg::W_WHEEL-1:0] i_rd_addr,
    input  logic                       i_wr_en,
    input  logic [wre_pkg::W_WHEEL-1:0] i_wr_addr,
    input  logic [W_DATA-1:0]          i_wr_data,
    output logic [W_DATA-1:0]          o_rd_data
);
    import wre_pkg::*;

    logic [W_DATA-1:0]   r_mem [N_WHEELS];
    logic [N_WHEELS-1:0] r_vld;
    logic [W_DATA-1:0]   r_rd_data;
    logic                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

[design/wheel_rpm_estimator.sv]
// wheel_rpm_estimator: top level, sequencer and filter datapath.
// Depends on wre_pkg, wre_if, wre_cfg, wre_div and wre_wheel_ram.

// Four-wheel encoder rpm estimator. Each input word carries a millisecond tick
// and four encoder counts; each accepted word yields exactly one output word
// with the four filtered rpms and the mean of the middle two. The wheels are
// processed one after another out of a small state memory: read the wheel
// record, form the count delta and numerator, divide by the pulses per
// revolution times the clamped elapsed time in a shared one-bit-per-cycle
// divider (31 quotient bits), update the exponential filter and write the
// record back. The time from acceptance to a loaded output register is set
// by the four serial divisions; a word arriving while the stored time is zero
// skips the wheels. The input is ready again as soon as the output register
// loads, so a word is accepted only once the previous one is fully processed.
// A new input word is taken as soon as the sequencer is idle, even while the
// previous result still waits in the output register.
// Configuration writes are taken at any time but are only meaningful while
// the block is idle.

module wheel_rpm_estimator #(
    parameter int FRAC_BITS = wre_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wre_in_if.sink      i_in,
    wre_out_if.source   o_out,
    wre_cfg_if.sink     i_cfg
);
    import wre_pkg::*;

    localparam int W_F    = W_RPM + FRAC_BITS;   // filter state
    localparam int W_P    = W_F + W_GAIN + 1;    // gain product
    localparam int W_S    = W_P + 1;             // product sum
    localparam int W_REC  = W_CNT + W_F;
    localparam int W_SUM4 = W_RPM + 2;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_PREP   = 13'b0000000000010,
        S_DIVR   = 13'b0000000000100,
        S_RD     = 13'b0000000001000,
        S_DELTA  = 13'b0000000010000,
        S_DSTART = 13'b0000000100000,
        S_DWAIT  = 13'b0000001000000,
        S_FMUL   = 13'b0000010000000,
        S_FSUM   = 13'b0000100000000,
        S_FWB    = 13'b0001000000000,
        S_AVG1   = 13'b0010000000000,
        S_AVG2   = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    t_cfg cfg;

    logic [W_TIME-1:0]        r_time;
    logic [W_TIME-1:0]        r_last_time;
    logic [W_CNT-1:0]         r_cnt [N_WHEELS];
    logic [W_LIM-1:0]         r_elapsed;
    logic [W_DEN-1:0]         r_den;
    logic [W_WHEEL-1:0]       r_wheel;
    logic [W_NUM-1:0]         r_num;
    logic                     r_neg;
    logic signed [W_F-1:0]    r_fold;
    logic signed [W_RPM-1:0]  r_c;
    logic signed [W_P-1:0]    r_p1;
    logic signed [W_P-1:0]    r_p2;
    logic signed [W_S-1:0]    r_sum;
    logic signed [W_RPM-1:0]  r_rpm [N_WHEELS];
    logic signed [W_SUM4-1:0] r_sum4;
    logic signed [W_RPM-1:0]  r_max;
    logic signed [W_RPM-1:0]  r_min;
    logic signed [W_RPM-1:0]  r_avg;

    logic                     r_out_valid;
    logic signed [W_RPM-1:0]  r_out_rpm [N_WHEELS];
    logic signed [W_RPM-1:0]  r_out_avg;

    // ---------------------------------------------------------------- parts
    wre_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    logic              div_start;
    logic              div_busy;
    logic [W_NUM-1:0]  div_quot;

    wre_div #(
        .W_N (W_NUM),
        .W_D (W_DEN)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    logic              ram_rd_en;
    logic              ram_wr_en;
    logic [W_REC-1:0]  ram_rd_data;
    logic [W_REC-1:0]  ram_wr_data;

    wre_wheel_ram #(
        .W_DATA (W_REC)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_wheel),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_wheel),
        .i_wr_data (ram_wr_data),
        .o_rd_data (ram_rd_data)
    );

    // ---------------------------------------------------------------- control
    logic in_fire;
    logic out_free;
    logic last_wheel;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;
    assign last_wheel = (r_wheel == W_WHEEL'(N_WHEELS - 1));
    assign div_start  = (r_state == S_DSTART);
    assign ram_rd_en  = (r_state == S_RD);
    assign ram_wr_en  = (r_state == S_FWB);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in.valid) n_state = S_PREP;
            S_PREP:   n_state = (r_last_time == '0) ? S_DONE : S_DIVR;
            S_DIVR:   n_state = S_RD;
            S_RD:     n_state = S_DELTA;
            S_DELTA:  n_state = S_DSTART;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT:  if (!div_busy) n_state = S_FMUL;
            S_FMUL:   n_state = S_FSUM;
            S_FSUM:   n_state = S_FWB;
            S_FWB:    n_state = last_wheel ? S_AVG1 : S_RD;
            S_AVG1:   n_state = S_AVG2;
            S_AVG2:   n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_time <= '0;
            r_wheel     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PREP) begin
                r_last_time <= r_time;
            end
            if (r_state == S_DIVR) begin
                r_wheel <= '0;
            end else if (r_state == S_FWB) begin
                r_wheel <= r_wheel + W_WHEEL'(1);
            end
        end
    end

    // ---------------------------------------------------------------- elapsed
    logic [W_TIME-1:0] diff;
    logic [W_LIM-1:0]  elapsed;

    assign diff = r_time - r_last_time;

    always_comb begin
        priority if (diff == '0) begin
            elapsed = W_LIM'(1);
        end else if (diff > W_TIME'(cfg.lim)) begin
            elapsed = cfg.lim;
        end else begin
            elapsed = diff[W_LIM-1:0];
        end
    end

    // ---------------------------------------------------------------- delta
    logic [W_CNT-1:0]   prev_cnt;
    logic [W_CNT-1:0]   d16;
    logic signed [W_CNT:0] d17;
    logic signed [W_CNT:0] dsig;
    logic [W_CNT:0]     dmag;
    logic [2*W_CNT-1:0] num_full;

    assign prev_cnt = ram_rd_data[W_REC-1 -: W_CNT];
    assign d16      = r_cnt[r_wheel] - prev_cnt;
    assign d17      = $signed({d16[W_CNT-1], d16});
    assign dsig     = cfg.inv[r_wheel] ? -d17 : d17;
    assign dmag     = dsig[W_CNT] ? -dsig : dsig;
    assign num_full = dmag[W_CNT-1:0] * MS_PER_MIN;

    // ---------------------------------------------------------------- filter
    logic [W_RPM-2:0]      cmag;
    logic signed [W_F-1:0] fc;
    logic                  fold_zero;
    logic [W_GAIN-1:0]     g_sel;
    logic [W_GAIN-1:0]     g_rest;
    logic signed [W_S-1:0] sum_b;
    logic signed [W_S-1:0] f_wide;
    logic signed [W_F-1:0] f_new;
    logic signed [W_F-1:0] f_b;
    logic signed [W_RPM-1:0] rpm_new;

    assign cmag = (div_quot > W_NUM'(RPM_LIMIT)) ? RPM_LIMIT : div_quot[W_RPM-2:0];

    // a zero state takes the new value outright: weight one, old weight zero
    assign fc        = $signed({r_c, {FRAC_BITS{1'b0}}});
    assign fold_zero = (r_fold == '0);
    assign g_sel     = fold_zero ? GAIN_ONE : cfg.gain;
    assign g_rest    = GAIN_ONE - g_sel;

    // divide by 256 and by 2^FRAC_BITS, both truncating toward zero
    assign sum_b   = r_sum + (r_sum[W_S-1] ? W_S'(255) : W_S'(0));
    assign f_wide  = sum_b >>> 8;
    assign f_new   = f_wide[W_F-1:0];
    assign f_b     = f_new + (f_new[W_F-1] ? W_F'((1 << FRAC_BITS) - 1) : W_F'(0));
    assign rpm_new = f_b[W_F-1 -: W_RPM];

    assign ram_wr_data = {r_cnt[r_wheel], f_new};

    // ---------------------------------------------------------------- average
    logic signed [W_RPM-1:0]  mx01, mx23, mn01, mn23;
    logic signed [W_SUM4-1:0] mid;
    logic signed [W_SUM4-1:0] mid_b;

    assign mx01 = (r_rpm[0] > r_rpm[1]) ? r_rpm[0] : r_rpm[1];
    assign mn01 = (r_rpm[0] > r_rpm[1]) ? r_rpm[1] : r_rpm[0];
    assign mx23 = (r_rpm[2] > r_rpm[3]) ? r_rpm[2] : r_rpm[3];
    assign mn23 = (r_rpm[2] > r_rpm[3]) ? r_rpm[3] : r_rpm[2];

    assign mid   = r_sum4 - W_SUM4'(r_max) - W_SUM4'(r_min);
    assign mid_b = mid + (mid[W_SUM4-1] ? W_SUM4'(1) : W_SUM4'(0));

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_time   <= i_in.time_ms;
            r_cnt[0] <= i_in.count_wheel1;
            r_cnt[1] <= i_in.count_wheel2;
            r_cnt[2] <= i_in.count_wheel3;
            r_cnt[3] <= i_in.count_wheel4;
        end
        if (r_state == S_PREP) begin
            r_elapsed <= elapsed;
            if (r_last_time == '0) begin
                for (int i = 0; i < N_WHEELS; i++) begin
                    r_rpm[i] <= '0;
                end
                r_avg <= '0;
            end
        end
        if (r_state == S_DIVR) begin
            r_den <= W_DEN'(cfg.ppr) * W_DEN'(r_elapsed);
        end
        if (r_state == S_DELTA) begin
            r_num  <= num_full[W_NUM-1:0];
            r_neg  <= dsig[W_CNT];
            r_fold <= $signed(ram_rd_data[W_F-1:0]);
        end
        if (r_state == S_DWAIT && !div_busy) begin
            r_c <= r_neg ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
        end
        if (r_state == S_FMUL) begin
            r_p1 <= fc * $signed({1'b0, g_sel});
            r_p2 <= r_fold * $signed({1'b0, g_rest});
        end
        if (r_state == S_FSUM) begin
            r_sum <= W_S'(r_p1) + W_S'(r_p2);
        end
        if (r_state == S_FWB) begin
            r_rpm[r_wheel] <= rpm_new;
        end
        if (r_state == S_AVG1) begin
            r_max  <= (mx01 > mx23) ? mx01 : mx23;
            r_min  <= (mn01 > mn23) ? mn23 : mn01;
            r_sum4 <= W_SUM4'(r_rpm[0]) + W_SUM4'(r_rpm[1])
                    + W_SUM4'(r_rpm[2]) + W_SUM4'(r_rpm[3]);
        end
        if (r_state == S_AVG2) begin
            r_avg <= W_RPM'(mid_b >>> 1);
        end
    end

    // ---------------------------------------------------------------- output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            for (int i = 0; i < N_WHEELS; i++) begin
                r_out_rpm[i] <= r_rpm[i];
            end
            r_out_avg <= r_avg;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.rpm_wheel1 = r_out_rpm[0];
    assign o_out.rpm_wheel2 = r_out_rpm[1];
    assign o_out.rpm_wheel3 = r_out_rpm[2];
    assign o_out.rpm_wheel4 = r_out_rpm[3];
    assign o_out.mean_rpm   = r_out_avg;

endmodule

[bench/wre_rpm_checker.sv]
// wre_rpm_checker: watches the input, output and register channels of the wheel rpm
// estimator, predicts every result word and compares it field by field.
// Depends on wre_pkg and wre_if.

module wre_rpm_checker #(
    parameter int FRAC_BITS = wre_pkg::FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    wre_in_if    i_in_mon,
    wre_out_if   i_out_mon,
    wre_cfg_if   i_cfg_mon,
    input  logic i_end,
    output int   o_fail_count,
    output int   o_pending
);
    import wre_pkg::*;

    localparam int AVG_FIELD = N_WHEELS;

    // index 0..3 are the wheels, AVG_FIELD the middle-two mean
    typedef logic [AVG_FIELD:0][W_RPM-1:0] rpm_word_t;
    typedef logic [N_WHEELS-1:0][W_CNT-1:0] count_set_t;

    const string field_name [AVG_FIELD+1] = '{"rpm_wheel1", "rpm_wheel2", "rpm_wheel3",
                                              "rpm_wheel4", "mean_rpm"};

    // shadow registers
    logic [W_PPR-1:0]  ppr_reg;
    logic [W_GAIN-1:0] gain_reg;
    logic [W_LIM-1:0]  lim_reg;
    logic [W_INV-1:0]  inv_reg;

    // shadow wheel state
    logic [W_CNT-1:0]  prev_cnt [N_WHEELS];
    logic [W_TIME-1:0] last_tick;
    longint            filt_state [N_WHEELS];

    rpm_word_t pending_rpm_words [$];
    int        fail_cnt = 0;
    bit        end_seen = 1'b0;

    assign o_fail_count = fail_cnt;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fail_cnt++;
    endtask

    function automatic rpm_word_t predict_rpm_word(input logic [W_TIME-1:0] tick,
                                                   input count_set_t cnts);
        rpm_word_t         w;
        logic [W_TIME-1:0] elapsed;
        longint            lim_eff, ppr_eff, g, d, c, fc, tmp;
        longint            rpm_lim, per_min, full, one;
        longint            rpm [N_WHEELS];
        longint            srt [N_WHEELS];

        w = '0;
        // stored time zero: just record the tick
        if (last_tick == '0) begin
            last_tick = tick;
            return w;
        end
        rpm_lim = longint'(RPM_LIMIT);
        per_min = longint'(MS_PER_MIN);
        full    = longint'(GAIN_ONE);
        one     = longint'(1) << FRAC_BITS;

        elapsed = tick - last_tick;
        lim_eff = (lim_reg == '0) ? 1 : longint'(lim_reg);
        if (elapsed == '0) elapsed = 1;
        if (elapsed > lim_eff) elapsed = W_TIME'(lim_eff);
        ppr_eff = (ppr_reg == '0) ? 1 : longint'(ppr_reg);
        g = (gain_reg > GAIN_ONE) ? full : longint'(gain_reg);

        for (int i = 0; i < N_WHEELS; i++) begin
            d = $signed(cnts[i] - prev_cnt[i]);
            if (inv_reg[i]) d = -d;
            prev_cnt[i] = cnts[i];
            c = (d * per_min) / (ppr_eff * longint'(elapsed));
            if (c > rpm_lim) c = rpm_lim;
            if (c < -rpm_lim) c = -rpm_lim;
            fc = c * one;
            if (filt_state[i] == 0)
                filt_state[i] = fc;
            else
                filt_state[i] = (g * fc + (full - g) * filt_state[i]) / full;
            rpm[i] = filt_state[i] / one;
            srt[i] = rpm[i];
            w[i] = W_RPM'(rpm[i]);
        end
        last_tick = tick;

        for (int i = 0; i < N_WHEELS - 1; i++) begin
            for (int j = 0; j < N_WHEELS - 1 - i; j++) begin
                if (srt[j] > srt[j+1]) begin
                    tmp      = srt[j];
                    srt[j]   = srt[j+1];
                    srt[j+1] = tmp;
                end
            end
        end
        w[AVG_FIELD] = W_RPM'((srt[1] + srt[2]) / 2);
        return w;
    endfunction

    always @(posedge i_clk) begin : monitor
        rpm_word_t got, want;
        if (!i_rst_n) begin
            ppr_reg   = PPR_RST;
            gain_reg  = GAIN_RST;
            lim_reg   = LIM_RST;
            inv_reg   = INV_RST;
            last_tick = '0;
            for (int i = 0; i < N_WHEELS; i++) begin
                prev_cnt[i]   = '0;
                filt_state[i] = 0;
            end
            pending_rpm_words.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = {i_out_mon.mean_rpm, i_out_mon.rpm_wheel4, i_out_mon.rpm_wheel3,
                       i_out_mon.rpm_wheel2, i_out_mon.rpm_wheel1};
                if (pending_rpm_words.size() == 0) begin
                    report_error($sformatf("result word with nothing expected, %s=%0d",
                                           field_name[AVG_FIELD],
                                           $signed(got[AVG_FIELD])));
                end else begin
                    want = pending_rpm_words.pop_front();
                    for (int f = 0; f <= AVG_FIELD; f++) begin
                        if (got[f] !== want[f])
                            report_error($sformatf("%s expected %0d, got %0d", field_name[f],
                                                   $signed(want[f]), $signed(got[f])));
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                pending_rpm_words.push_back(predict_rpm_word(i_in_mon.time_ms,
                    {i_in_mon.count_wheel4, i_in_mon.count_wheel3,
                     i_in_mon.count_wheel2, i_in_mon.count_wheel1}));
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                case (t_cfg_idx'(i_cfg_mon.index))
                    CFG_PPR:  ppr_reg  = i_cfg_mon.data[W_PPR-1:0];
                    CFG_GAIN: gain_reg = i_cfg_mon.data[W_GAIN-1:0];
                    CFG_LIM:  lim_reg  = i_cfg_mon.data[W_LIM-1:0];
                    CFG_INV:  inv_reg  = i_cfg_mon.data[W_INV-1:0];
                    default:  ;
                endcase
            end
            if (i_end && !end_seen) begin
                end_seen = 1'b1;
                if (pending_rpm_words.size() != 0)
                    report_error($sformatf("%0d result words never arrived",
                                           pending_rpm_words.size()));
            end
        end
        o_pending <= pending_rpm_words.size();
    end

endmodule

[bench/wheel_rpm_estimator_tb.sv]
// wheel_rpm_estimator_tb: drives samples and register writes into the wheel rpm
// estimator with random idling and gives the verdict.
// Depends on wre_pkg, wre_if, wre_rpm_checker and the design.

module wheel_rpm_estimator_tb;
    import wre_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 250;
    localparam int N_PHASES       = 8;
    localparam int PHASE_ITEMS    = 116;

    typedef logic [N_WHEELS-1:0][W_CNT-1:0] count_set_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wre_in_if  in_ch ();
    wre_out_if out_ch ();
    wre_cfg_if cfg_ch ();

    bit         sim_end     = 1'b0;
    bit         send_gaps   = 1'b1;
    bit         recv_stalls = 1'b1;
    int         fail_count;
    int         pending_count;
    int         idle_cycles = 0;
    int         phase_lim   = LIM_RST;
    logic [W_TIME-1:0] cur_tick = '0;
    count_set_t        cur_cnt  = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    wheel_rpm_estimator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    wre_rpm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_mon    (cfg_ch),
        .i_end        (sim_end),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // receiver back-pressure
    always @(negedge i_clk) begin
        out_ch.ready = !(recv_stalls && $urandom_range(99) < 14);
    end

    // watchdog: cycles with no word moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // valid stays high after acceptance until the next call or drain lowers it
    task automatic send_word(input logic [W_TIME-1:0] tick, input count_set_t cnts);
        @(negedge i_clk);
        while (send_gaps && $urandom_range(99) < 14) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.time_ms      = tick;
        in_ch.count_wheel1 = cnts[0];
        in_ch.count_wheel2 = cnts[1];
        in_ch.count_wheel3 = cnts[2];
        in_ch.count_wheel4 = cnts[3];
        do @(posedge i_clk); while (!in_ch.ready);
        cur_tick = tick;
        cur_cnt  = cnts;
    endtask

    task automatic step_word(input logic [W_TIME-1:0] dt, input count_set_t deltas);
        count_set_t nxt;
        for (int i = 0; i < N_WHEELS; i++) nxt[i] = cur_cnt[i] + deltas[i];
        send_word(cur_tick + dt, nxt);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [W_CFG_DATA-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // registers only change with the block idle
    task automatic set_config(input logic [W_PPR-1:0] ppr, input logic [W_GAIN-1:0] gain,
                              input logic [W_LIM-1:0] lim, input logic [W_INV-1:0] inv);
        drain();
        write_reg(CFG_PPR, W_CFG_DATA'(ppr));
        write_reg(CFG_GAIN, W_CFG_DATA'(gain));
        write_reg(CFG_LIM, W_CFG_DATA'(lim));
        write_reg(CFG_INV, W_CFG_DATA'(inv));
        phase_lim = int'(lim);
    endtask

    function automatic logic [W_CNT-1:0] rand_delta();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick <= 5) return W_CNT'(int'($urandom_range(400)) - 200);
        if (pick <= 8) return W_CNT'(int'($urandom_range(8000)) - 4000);
        return W_CNT'($urandom);
    endfunction

    // mostly plausible sampling, some raw noise and zero ticks
    task automatic random_item();
        int                pick;
        int                lim_eff;
        logic [W_TIME-1:0] dt;
        count_set_t        deltas;
        pick    = $urandom_range(99);
        lim_eff = (phase_lim == 0) ? 1 : phase_lim;
        for (int i = 0; i < N_WHEELS; i++) deltas[i] = rand_delta();
        if (pick < 4) begin
            send_word('0, {$urandom, $urandom});
        end else if (pick < 16) begin
            send_word($urandom, {$urandom, $urandom});
        end else begin
            case ($urandom_range(9))
                0:       dt = '0;
                1:       dt = lim_eff + $urandom_range(1, 500);
                2:       dt = -$urandom_range(1, 1000);
                default: dt = $urandom_range(lim_eff, 1);
            endcase
            if ($urandom_range(11) == 0) deltas = '0;
            step_word(dt, deltas);
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.time_ms      = '0;
        in_ch.count_wheel1 = '0;
        in_ch.count_wheel2 = '0;
        in_ch.count_wheel3 = '0;
        in_ch.count_wheel4 = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_PPR;
        cfg_ch.data        = '0;
        out_ch.ready       = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, reset configuration first
        send_word('0, '0);                         // tick zero only records
        send_word('0, {4{16'hFFFF}});              // still zero, counts unused
        send_word(32'd1000, '0);
        step_word(10, {4{16'd100}});
        step_word(0, {4{16'd50}});                 // time stands still
        step_word(-500, {16'd7, 16'd9, 16'd11, 16'd13});  // time goes back
        step_word(10, {16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF});  // full-scale deltas
        step_word(10, {16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000});
        step_word(10, '0);
        send_word(32'hFFFF_FFFF, {4{16'hFFFF}});
        step_word(5, {4{16'h0001}});               // tick and counters wrap
        send_word('0, {16'd3, 16'd2, 16'd1, 16'd0});   // sample at tick zero
        step_word(20, {4{16'd40}});                // only records again
        step_word(20, {4{16'd40}});

        set_config('0, '0, '0, 4'hF);              // zero ppr, gain and limit
        step_word(3, {16'd40, 16'hFFD0, 16'd29, 16'd30});  // saturation edge
        step_word(1, {16'd100, 16'd100, 16'hFF00, 16'd5});

        set_config(16'd1, 9'h1FF, 10'd1000, 4'h0); // gain above full scale
        step_word(1000, {16'd500, 16'hFE00, 16'd30, 16'hFFE2});
        step_word(1500, {4{16'h8000}});
        step_word(1, {16'd30, 16'hFFE2, 16'd29, 16'hFFE3});

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: set_config(PPR_RST, GAIN_RST, LIM_RST, INV_RST);
                1: set_config(16'd1, GAIN_ONE, 10'd1, 4'hF);
                2: set_config(16'hFFFF, '0, 10'd1000, 4'h0);
                3: set_config('0, 9'h1FF, 10'h3FF, 4'h5);
                4: set_config(W_PPR'($urandom), W_GAIN'($urandom),
                              W_LIM'($urandom), W_INV'($urandom));
                default: set_config(W_PPR'($urandom_range(1, 2000)),
                                    W_GAIN'($urandom_range(0, 300)),
                                    W_LIM'($urandom_range(1, 1023)),
                                    W_INV'($urandom_range(0, 15)));
            endcase
            // first phase runs with no idling on either side
            send_gaps   = (p != 0);
            recv_stalls = (p != 0);
            repeat (PHASE_ITEMS) random_item();
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        sim_end = 1'b1;
        @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
design/wre_pkg.sv
design/wre_if.sv
design/wre_cfg.sv
design/wre_div.sv
design/wre_wheel_ram.sv
design/wheel_rpm_estimator.sv
bench/wre_rpm_checker.sv
bench/wheel_rpm_estimator_tb.sv
